/* rtl/lbsc_pkg.sv */
// Shared types and constants for the buffer slot cache.
package lbsc_pkg;

  localparam int ID_W         = 48;
  localparam int DIM_W        = 16;
  localparam int STRIDE_W     = 18;
  localparam int FRAME_W      = 32;
  localparam int IDX_OUT_W    = 3;
  localparam int SLOT_COUNT_DEF = 4;

  // One cache slot: key (identity plus geometry) and its last-used frame.
  typedef struct packed {
    logic [ID_W-1:0]     identity;
    logic [DIM_W-1:0]    width;
    logic [DIM_W-1:0]    height;
    logic [STRIDE_W-1:0] stride;
    logic [FRAME_W-1:0]  last_used;
  } slot_t;

  // Write enables for the slot store.
  typedef struct packed {
    logic key_en;
    logic time_en;
  } slot_wr_t;

  // Result of comparing one stored slot against the request.
  typedef struct packed {
    logic empty;
    logic key_eq;
    logic geom_eq;
    logic older;
  } cmp_res_t;

endpackage

/* rtl/lbsc_slot_store.sv */
// Slot register file with one scan read port and one write port.
module lbsc_slot_store
  import lbsc_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int IDX_W      = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] rd_idx,
  output slot_t            rd_entry,
  input  slot_wr_t         wr,
  input  logic [IDX_W-1:0] wr_idx,
  input  slot_t            wr_entry
);

  slot_t slots [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slots[i] <= '0;
      end
    end else begin
      if (wr.key_en) begin
        slots[wr_idx].identity <= wr_entry.identity;
        slots[wr_idx].width    <= wr_entry.width;
        slots[wr_idx].height   <= wr_entry.height;
        slots[wr_idx].stride   <= wr_entry.stride;
      end
      if (wr.time_en) begin
        slots[wr_idx].last_used <= wr_entry.last_used;
      end
    end
  end

  assign rd_entry = slots[rd_idx];

endmodule

/* rtl/lbsc_compare.sv */
// Shared compare unit: checks one stored slot against the request.
module lbsc_compare
  import lbsc_pkg::*;
(
  input  slot_t              entry,
  input  slot_t              req,
  input  logic [FRAME_W-1:0] ref_time,
  output cmp_res_t           res
);

  always_comb begin
    res.empty   = (entry.identity == '0);
    res.key_eq  = (entry.identity == req.identity);
    res.geom_eq = (entry.width == req.width) && (entry.height == req.height) &&
                  (entry.stride == req.stride);
    // Unsigned frame compare, no wrap handling.
    res.older   = (entry.last_used < ref_time);
  end

endmodule

/* rtl/lru_buffer_slot_cache.sv */
// Top level of the fully associative buffer slot cache with LRU replacement.
// Flow: an accepted word is checked against every slot in turn by the shared
//   compare unit (a zero identity skips the scan), then the result register
//   is loaded; a new word is not accepted until the block is back in idle.
// Reset: synchronous, clears every slot to empty with zero geometry and
//   last-used frame, and empties both channels.
module lru_buffer_slot_cache
  import lbsc_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // Request channel.
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ID_W-1:0]      buffer_identity,
  input  logic [DIM_W-1:0]     buffer_width,
  input  logic [DIM_W-1:0]     height_px,
  input  logic [STRIDE_W-1:0]  stride_bytes,
  input  logic [FRAME_W-1:0]   frame_number,
  input  logic                 import_ok,
  // Result channel.
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 hit,
  output logic [IDX_OUT_W-1:0] slot_index,
  output logic                 donor_valid,
  output logic [IDX_OUT_W-1:0] donor_slot,
  output logic                 evicted_occupied,
  output logic                 installed,
  output logic                 request_error
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  // The block idles in S_IDLE, walks every slot once in S_SCAN, and in
  // S_FINISH decides the outcome, updates the table and loads the result
  // register once that register is free.
  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_t;

  state_t             state;
  slot_t              req;
  logic               req_ok;
  logic               req_err;
  logic [IDX_W-1:0]   idx;

  // Scan findings, all gathered in a single pass over the slots.
  logic               hit_found;
  logic [IDX_W-1:0]   hit_idx;
  logic               empty_found;
  logic [IDX_W-1:0]   empty_idx;
  logic               donor_found;
  logic [IDX_W-1:0]   donor_idx;
  logic               lru_found;
  logic [IDX_W-1:0]   lru_idx;
  logic [FRAME_W-1:0] lru_time;

  slot_t              rd_entry;
  cmp_res_t           cmp;
  slot_wr_t           wr;
  logic [IDX_W-1:0]   wr_idx;

  logic               in_take;
  logic               out_take;
  logic               finish_go;
  logic [IDX_W-1:0]   victim;
  logic               donor_ok;
  logic               miss;

  lbsc_slot_store #(
    .SLOT_COUNT (SLOT_COUNT),
    .IDX_W      (IDX_W)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_idx   (idx),
    .rd_entry (rd_entry),
    .wr       (wr),
    .wr_idx   (wr_idx),
    .wr_entry (req)
  );

  lbsc_compare u_cmp (
    .entry    (rd_entry),
    .req      (req),
    .ref_time (lru_time),
    .res      (cmp)
  );

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  // The result register may be reloaded in the same cycle it is taken.
  assign finish_go = (state == S_FINISH) && (!out_valid || !out_stall);

  // The first empty slot wins; with none empty, the oldest occupied slot
  // (first among equals) is replaced. A donor that is also the victim is
  // dropped rather than replaced by a later candidate.
  assign victim   = empty_found ? empty_idx : lru_idx;
  assign donor_ok = donor_found && (donor_idx != victim);
  assign miss     = !req_err && !hit_found;

  // A hit only refreshes the last-used frame; a miss with a good import
  // writes the whole key into the victim. A zero identity leaves the table.
  always_comb begin
    wr_idx     = hit_found ? hit_idx : victim;
    wr.time_en = finish_go && !req_err && (hit_found || req_ok);
    wr.key_en  = finish_go && miss && req_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // A result taken in the cycle a new one is loaded stays valid.
      if (out_take && !finish_go) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_take) begin
            req.identity  <= buffer_identity;
            req.width     <= buffer_width;
            req.height    <= height_px;
            req.stride    <= stride_bytes;
            req.last_used <= frame_number;
            req_ok        <= import_ok;
            req_err       <= (buffer_identity == '0);
            idx           <= '0;
            hit_found     <= 1'b0;
            hit_idx       <= '0;
            empty_found   <= 1'b0;
            empty_idx     <= '0;
            donor_found   <= 1'b0;
            donor_idx     <= '0;
            lru_found     <= 1'b0;
            lru_idx       <= '0;
            lru_time      <= '0;
            state         <= (buffer_identity == '0) ? S_FINISH : S_SCAN;
          end
        end

        S_SCAN: begin
          if (!cmp.empty && cmp.key_eq && cmp.geom_eq && !hit_found) begin
            hit_found <= 1'b1;
            hit_idx   <= idx;
          end
          if (cmp.empty && !empty_found) begin
            empty_found <= 1'b1;
            empty_idx   <= idx;
          end
          if (!cmp.empty && cmp.geom_eq && !donor_found) begin
            donor_found <= 1'b1;
            donor_idx   <= idx;
          end
          if (!cmp.empty && (!lru_found || cmp.older)) begin
            lru_found <= 1'b1;
            lru_idx   <= idx;
            lru_time  <= rd_entry.last_used;
          end
          if (idx == LAST_IDX) begin
            state <= S_FINISH;
          end else begin
            idx <= idx + 1'b1;
          end
        end

        S_FINISH: begin
          if (finish_go) begin
            out_valid        <= 1'b1;
            request_error    <= req_err;
            hit              <= !req_err && hit_found;
            slot_index       <= req_err ? '0 :
                                IDX_OUT_W'(hit_found ? hit_idx : victim);
            donor_valid      <= miss && donor_ok;
            donor_slot       <= (miss && donor_ok) ? IDX_OUT_W'(donor_idx) : '0;
            evicted_occupied <= miss && req_ok && !empty_found;
            installed        <= miss && req_ok;
            state            <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A hit never reports miss-side actions.
  a_hit_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> !installed && !donor_valid && !evicted_occupied)
    else $error("hit result carries miss-side flags");

  // A rejected request touches nothing and reports nothing else.
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && request_error |-> !hit && !installed && !donor_valid)
    else $error("error result carries other flags");

  // An eviction is only reported as part of an install.
  a_evict_install: assert property (@(posedge clk) disable iff (rst)
    out_valid && evicted_occupied |-> installed)
    else $error("eviction without install");

  // The donor is never the slot being replaced.
  a_donor_distinct: assert property (@(posedge clk) disable iff (rst)
    out_valid && donor_valid |-> donor_slot != slot_index)
    else $error("donor equals victim");

  // The table is written only in the cycle that delivers the result.
  a_write_at_finish: assert property (@(posedge clk) disable iff (rst)
    wr.time_en || wr.key_en |=> out_valid)
    else $error("table written without a result");

endmodule
